FILE: hdl/pnf_pkg.sv
// Shared constants, types and helper functions of the 3D gradient noise block.
`default_nettype none
package pnf_pkg;

  // Fixed point format of all internal values
  localparam int FRAC_BITS   = 16;
  localparam int ONE_FX      = 1 << FRAC_BITS;
  localparam int MAX_OCTAVES = 8;
  localparam int TABLE_SIZE  = 256;
  localparam int TIDX_W      = $clog2(TABLE_SIZE);

  // Datapath widths
  localparam int DW    = 45;  // wide signed accumulator and lerp values
  localparam int BW    = 25;  // signed narrow multiplier operand (fades, reciprocals)
  localparam int FW    = FRAC_BITS + 1;  // signed fraction
  localparam int GW    = 19;  // signed gradient dot product
  localparam int OUT_W = 19;  // signed Q3.16 result
  localparam int CW    = 32;  // coordinate width

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  // Request kinds carried in tuser
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_NOISE   = 2'd1;
  localparam logic [1:0] MODE_FBM     = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  // Multiplier operations
  localparam logic [2:0] MOP_FADE_INNER = 3'd0;
  localparam logic [2:0] MOP_FADE_SQ    = 3'd1;
  localparam logic [2:0] MOP_FADE_CUBE  = 3'd2;
  localparam logic [2:0] MOP_FADE_OUT   = 3'd3;
  localparam logic [2:0] MOP_LERP       = 3'd4;
  localparam logic [2:0] MOP_NORM       = 3'd5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load_item;
    logic       tbl_wr;
    logic       mul_start;
    logic [2:0] mul_op;
    logic [1:0] axis;
    logic [2:0] lerp_idx;
    logic       hash_rd;
    logic [1:0] hash_stage;
    logic [2:0] hash_corner;
    logic       grad_push;
    logic [2:0] push_corner;
    logic       acc;
    logic [2:0] octave;
    logic [3:0] oct_n;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mul_done;
    logic out_free;
  } sts_t;

  // Normalising factor round(2^16 * 2^n / (2^n - 1)) for n octaves
  function automatic logic [17:0] fbm_recip(input logic [3:0] n);
    logic [17:0] r;
    case (n)
      4'd1:    r = 18'd131072;
      4'd2:    r = 18'd87381;
      4'd3:    r = 18'd74898;
      4'd4:    r = 18'd69905;
      4'd5:    r = 18'd67650;
      4'd6:    r = 18'd66576;
      4'd7:    r = 18'd66052;
      4'd8:    r = 18'd65793;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

  // Gradient dot product picked by the low four hash bits
  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                input logic signed [FW:0] x,
                                                input logic signed [FW:0] y,
                                                input logic signed [FW:0] z);
    logic signed [GW-1:0] xs;
    logic signed [GW-1:0] ys;
    logic signed [GW-1:0] zs;
    logic signed [GW-1:0] r;
    xs = GW'(x);
    ys = GW'(y);
    zs = GW'(z);
    case (h)
      4'h0:    r = xs + ys;
      4'h1:    r = -xs + ys;
      4'h2:    r = xs - ys;
      4'h3:    r = -xs - ys;
      4'h4:    r = xs + zs;
      4'h5:    r = -xs + zs;
      4'h6:    r = xs - zs;
      4'h7:    r = -xs - zs;
      4'h8:    r = ys + zs;
      4'h9:    r = -ys + zs;
      4'hA:    r = ys - zs;
      4'hB:    r = -ys - zs;
      4'hC:    r = ys + xs;
      4'hD:    r = -ys + zs;
      4'hE:    r = ys - xs;
      default: r = -ys - zs;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/pnf_mul.sv
// Shared sign-magnitude fixed point multiplier, split into two partial products.
`default_nettype none
module pnf_mul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [pnf_pkg::DW-1:0] a,
  input  wire logic signed [pnf_pkg::BW-1:0] b,
  output logic                               done,
  output logic signed [pnf_pkg::DW-1:0]      p
);

  localparam int LO_W = 23;
  localparam int HI_W = pnf_pkg::DW - LO_W;
  localparam int PL_W = LO_W + pnf_pkg::BW;
  localparam int PH_W = HI_W + pnf_pkg::BW;
  localparam int FULL_W = pnf_pkg::DW + pnf_pkg::BW;

  logic [pnf_pkg::DW-1:0] am;
  logic [pnf_pkg::BW-1:0] bm;
  logic                   neg;
  logic [PL_W-1:0]        plo;
  logic [PH_W-1:0]        phi;
  logic [FULL_W-1:0]      full;
  logic                   c1;
  logic                   c2;
  logic                   c3;

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      c1   <= 1'b0;
      c2   <= 1'b0;
      c3   <= 1'b0;
      done <= 1'b0;
    end else begin
      c1   <= start;
      c2   <= c1;
      c3   <= c2;
      done <= c3;
    end
  end

  assign full = {phi, {LO_W{1'b0}}} + FULL_W'(plo);

  // Operand magnitudes, partial products, recombine and restore the sign
  always_ff @(posedge clk) begin
    if (start) begin
      am  <= a[pnf_pkg::DW-1] ? pnf_pkg::DW'(-a) : pnf_pkg::DW'(a);
      bm  <= b[pnf_pkg::BW-1] ? pnf_pkg::BW'(-b) : pnf_pkg::BW'(b);
      neg <= a[pnf_pkg::DW-1] ^ b[pnf_pkg::BW-1];
    end
    if (c1) begin
      plo <= PL_W'(PL_W'(am[LO_W-1:0]) * PL_W'(bm));
    end
    if (c2) begin
      phi <= PH_W'(PH_W'(am[pnf_pkg::DW-1:LO_W]) * PH_W'(bm));
    end
    if (c3) begin
      p <= neg ? -$signed(full[pnf_pkg::DW+pnf_pkg::FRAC_BITS-1:pnf_pkg::FRAC_BITS])
               : $signed(full[pnf_pkg::DW+pnf_pkg::FRAC_BITS-1:pnf_pkg::FRAC_BITS]);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pnf_datapath.sv
// Datapath: coordinate split, permutation memory, fade and lerp arithmetic, output register.
`default_nettype none
module pnf_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pnf_pkg::cmd_t                  cmd,
  output pnf_pkg::sts_t                       sts,
  input  wire logic signed [pnf_pkg::CW-1:0]  coord_x,
  input  wire logic signed [pnf_pkg::CW-1:0]  coord_y,
  input  wire logic signed [pnf_pkg::CW-1:0]  coord_z,
  input  wire logic [pnf_pkg::TIDX_W-1:0]     table_index,
  input  wire logic [7:0]                     table_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [pnf_pkg::OUT_W-1:0]    noise_value
);

  localparam int SH_W = pnf_pkg::CW + 8;

  // Coordinate magnitudes and signs
  logic [pnf_pkg::CW-1:0] mag_x, mag_y, mag_z;
  logic                   neg_x, neg_y, neg_z;
  logic [SH_W-1:0]        sh_x, sh_y, sh_z;
  logic [7:0]             cell_x, cell_y, cell_z;
  logic signed [pnf_pkg::FW-1:0] frac_x, frac_y, frac_z;

  // Permutation memory
  logic [7:0]             perm [pnf_pkg::TABLE_SIZE];
  logic [7:0]             rd;
  logic [7:0]             addr;

  // Arithmetic state
  logic signed [pnf_pkg::BW-1:0] inner, t2, t3, fade_u, fade_v, fade_w;
  logic signed [pnf_pkg::DW-1:0] q [8];
  logic signed [pnf_pkg::DW-1:0] sum;

  logic signed [pnf_pkg::FW-1:0] tsel;
  logic signed [pnf_pkg::BW-1:0] tb;
  logic signed [pnf_pkg::BW-1:0] inner_b;
  logic signed [pnf_pkg::BW-1:0] lerp_t;
  logic signed [pnf_pkg::DW-1:0] mul_a;
  logic signed [pnf_pkg::BW-1:0] mul_b;
  logic                          mul_done;
  logic signed [pnf_pkg::DW-1:0] mul_p;
  logic signed [pnf_pkg::DW-1:0] lerp_res;
  logic signed [pnf_pkg::FW:0]   gx, gy, gz;
  logic signed [pnf_pkg::GW-1:0] g;
  logic [pnf_pkg::DW-1:0]        nv_mag;
  logic [pnf_pkg::DW-1:0]        nv_sh;
  logic signed [pnf_pkg::DW-1:0] acc_term;
  logic signed [pnf_pkg::OUT_W-1:0] sat;

  // Split scaled coordinates into cell and signed fraction
  assign sh_x = SH_W'(mag_x) << cmd.octave;
  assign sh_y = SH_W'(mag_y) << cmd.octave;
  assign sh_z = SH_W'(mag_z) << cmd.octave;
  assign cell_x = neg_x ? 8'(-sh_x[23:16]) : sh_x[23:16];
  assign cell_y = neg_y ? 8'(-sh_y[23:16]) : sh_y[23:16];
  assign cell_z = neg_z ? 8'(-sh_z[23:16]) : sh_z[23:16];
  assign frac_x = neg_x ? -$signed({1'b0, sh_x[15:0]}) : $signed({1'b0, sh_x[15:0]});
  assign frac_y = neg_y ? -$signed({1'b0, sh_y[15:0]}) : $signed({1'b0, sh_y[15:0]});
  assign frac_z = neg_z ? -$signed({1'b0, sh_z[15:0]}) : $signed({1'b0, sh_z[15:0]});

  // Latch the request coordinates
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mag_x <= coord_x[pnf_pkg::CW-1] ? pnf_pkg::CW'(-coord_x) : pnf_pkg::CW'(coord_x);
      mag_y <= coord_y[pnf_pkg::CW-1] ? pnf_pkg::CW'(-coord_y) : pnf_pkg::CW'(coord_y);
      mag_z <= coord_z[pnf_pkg::CW-1] ? pnf_pkg::CW'(-coord_z) : pnf_pkg::CW'(coord_z);
      neg_x <= coord_x[pnf_pkg::CW-1];
      neg_y <= coord_y[pnf_pkg::CW-1];
      neg_z <= coord_z[pnf_pkg::CW-1];
    end
  end

  // Hash chain address: x cell, then previous hash plus y, then plus z
  always_comb begin
    case (cmd.hash_stage)
      2'd0:    addr = cell_x + 8'(cmd.hash_corner[0]);
      2'd1:    addr = rd + cell_y + 8'(cmd.hash_corner[1]);
      default: addr = rd + cell_z + 8'(cmd.hash_corner[2]);
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      perm[table_index] <= table_value;
    end
    if (cmd.hash_rd) begin
      rd <= perm[addr];
    end
  end

  // Fraction of the axis being faded
  always_comb begin
    case (cmd.axis)
      2'd1:    tsel = frac_y;
      2'd2:    tsel = frac_z;
      default: tsel = frac_x;
    endcase
  end

  assign tb      = pnf_pkg::BW'(tsel);
  assign inner_b = (tb <<< 2) + (tb <<< 1) - pnf_pkg::BW'(15 * pnf_pkg::ONE_FX);

  // Interpolation weight: x for the first four lerps, then y, then z
  always_comb begin
    if (cmd.lerp_idx < 3'd4) begin
      lerp_t = fade_u;
    end else if (cmd.lerp_idx < 3'd6) begin
      lerp_t = fade_v;
    end else begin
      lerp_t = fade_w;
    end
  end

  // Multiplier operand selection
  always_comb begin
    case (cmd.mul_op)
      pnf_pkg::MOP_FADE_INNER: begin
        mul_a = pnf_pkg::DW'(tsel);
        mul_b = inner_b;
      end
      pnf_pkg::MOP_FADE_SQ: begin
        mul_a = pnf_pkg::DW'(tsel);
        mul_b = tb;
      end
      pnf_pkg::MOP_FADE_CUBE: begin
        mul_a = pnf_pkg::DW'(t2);
        mul_b = tb;
      end
      pnf_pkg::MOP_FADE_OUT: begin
        mul_a = pnf_pkg::DW'(t3);
        mul_b = inner;
      end
      pnf_pkg::MOP_LERP: begin
        mul_a = q[1] - q[0];
        mul_b = lerp_t;
      end
      default: begin
        mul_a = sum;
        mul_b = $signed(pnf_pkg::BW'(pnf_pkg::fbm_recip(cmd.oct_n)));
      end
    endcase
  end

  pnf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign lerp_res = q[0] + mul_p;

  // Corner offsets for the gradient being stored
  assign gx = (pnf_pkg::FW+1)'(frac_x) -
              (cmd.push_corner[0] ? (pnf_pkg::FW+1)'(pnf_pkg::ONE_FX) : '0);
  assign gy = (pnf_pkg::FW+1)'(frac_y) -
              (cmd.push_corner[1] ? (pnf_pkg::FW+1)'(pnf_pkg::ONE_FX) : '0);
  assign gz = (pnf_pkg::FW+1)'(frac_z) -
              (cmd.push_corner[2] ? (pnf_pkg::FW+1)'(pnf_pkg::ONE_FX) : '0);
  assign g  = pnf_pkg::grad(rd[3:0], gx, gy, gz);

  // Octave weighting by a magnitude shift
  assign nv_mag   = q[0][pnf_pkg::DW-1] ? pnf_pkg::DW'(-q[0]) : pnf_pkg::DW'(q[0]);
  assign nv_sh    = nv_mag >> cmd.octave;
  assign acc_term = q[0][pnf_pkg::DW-1] ? -$signed(nv_sh) : $signed(nv_sh);

  // Fade temporaries, gradient queue and octave sum
  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (cmd.mul_op)
        pnf_pkg::MOP_FADE_INNER:
          inner <= pnf_pkg::BW'(mul_p) + pnf_pkg::BW'(10 * pnf_pkg::ONE_FX);
        pnf_pkg::MOP_FADE_SQ:   t2 <= pnf_pkg::BW'(mul_p);
        pnf_pkg::MOP_FADE_CUBE: t3 <= pnf_pkg::BW'(mul_p);
        pnf_pkg::MOP_FADE_OUT: begin
          case (cmd.axis)
            2'd1:    fade_v <= pnf_pkg::BW'(mul_p);
            2'd2:    fade_w <= pnf_pkg::BW'(mul_p);
            default: fade_u <= pnf_pkg::BW'(mul_p);
          endcase
        end
        pnf_pkg::MOP_LERP: begin
          // drop the two consumed entries, place the result behind the live ones
          for (int i = 0; i < 6; i++) begin
            q[i] <= (i == 6 - int'(cmd.lerp_idx)) ? lerp_res : q[i+2];
          end
          if (cmd.lerp_idx == 3'd0) begin
            q[6] <= lerp_res;
          end
        end
        default: sum <= mul_p;
      endcase
    end
    if (cmd.grad_push) begin
      for (int i = 0; i < 7; i++) begin
        q[i] <= q[i+1];
      end
      q[7] <= pnf_pkg::DW'(g);
    end
    if (cmd.load_item) begin
      sum <= '0;
    end else if (cmd.acc) begin
      sum <= sum + acc_term;
    end
  end

  // Saturate to the output format
  always_comb begin
    if (sum > pnf_pkg::DW'(pnf_pkg::OUT_MAX)) begin
      sat = pnf_pkg::OUT_W'(pnf_pkg::OUT_MAX);
    end else if (sum < pnf_pkg::DW'(pnf_pkg::OUT_MIN)) begin
      sat = pnf_pkg::OUT_W'(pnf_pkg::OUT_MIN);
    end else begin
      sat = sum[pnf_pkg::OUT_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      noise_value <= sat;
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

FILE: hdl/pnf_ctrl.sv
// Controller: request intake, octave count register and the per-octave sequence.
`default_nettype none
module pnf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    mode,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_wdata,
  output pnf_pkg::cmd_t      cmd,
  input  wire pnf_pkg::sts_t sts
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_FADE_GO   = 4'd1;
  localparam logic [3:0] ST_FADE_WAIT = 4'd2;
  localparam logic [3:0] ST_HASH      = 4'd3;
  localparam logic [3:0] ST_HASH_END  = 4'd4;
  localparam logic [3:0] ST_LERP_GO   = 4'd5;
  localparam logic [3:0] ST_LERP_WAIT = 4'd6;
  localparam logic [3:0] ST_ACC       = 4'd7;
  localparam logic [3:0] ST_NORM_GO   = 4'd8;
  localparam logic [3:0] ST_NORM_WAIT = 4'd9;
  localparam logic [3:0] ST_OUT       = 4'd10;

  logic [3:0] state;
  logic [3:0] step;
  logic [2:0] corner;
  logic [1:0] stage;
  logic       push_pend;
  logic [2:0] push_corner;
  logic [2:0] octave;
  logic [3:0] oct_n;
  logic       fbm;
  logic [3:0] octave_count;
  logic [3:0] oct_clamped;
  logic       accept;
  logic       last_oct;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_oct = ({1'b0, octave} == oct_n - 4'd1);

  always_comb begin
    if (octave_count == 4'd0) begin
      oct_clamped = 4'd1;
    end else if (octave_count > 4'(pnf_pkg::MAX_OCTAVES)) begin
      oct_clamped = 4'(pnf_pkg::MAX_OCTAVES);
    end else begin
      oct_clamped = octave_count;
    end
  end

  // Octave count register
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd4;
    end else if (cfg_we) begin
      octave_count <= cfg_wdata;
    end
  end

  // Sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      corner      <= '0;
      stage       <= '0;
      push_pend   <= 1'b0;
      push_corner <= '0;
      octave      <= '0;
      oct_n       <= 4'd1;
      fbm         <= 1'b0;
    end else begin
      push_pend   <= (state == ST_HASH) && (stage == 2'd2);
      push_corner <= corner;
      case (state)
        ST_IDLE: begin
          if (accept && (mode == pnf_pkg::MODE_NOISE || mode == pnf_pkg::MODE_FBM)) begin
            octave <= '0;
            oct_n  <= (mode == pnf_pkg::MODE_FBM) ? oct_clamped : 4'd1;
            fbm    <= (mode == pnf_pkg::MODE_FBM);
            step   <= '0;
            state  <= ST_FADE_GO;
          end
        end
        ST_FADE_GO: state <= ST_FADE_WAIT;
        ST_FADE_WAIT: begin
          if (sts.mul_done) begin
            if (step == 4'd11) begin
              corner <= '0;
              stage  <= '0;
              state  <= ST_HASH;
            end else begin
              step  <= step + 4'd1;
              state <= ST_FADE_GO;
            end
          end
        end
        ST_HASH: begin
          if (stage == 2'd2) begin
            stage <= '0;
            if (corner == 3'd7) begin
              state <= ST_HASH_END;
            end else begin
              corner <= corner + 3'd1;
            end
          end else begin
            stage <= stage + 2'd1;
          end
        end
        ST_HASH_END: begin
          step  <= '0;
          state <= ST_LERP_GO;
        end
        ST_LERP_GO: state <= ST_LERP_WAIT;
        ST_LERP_WAIT: begin
          if (sts.mul_done) begin
            if (step == 4'd6) begin
              state <= ST_ACC;
            end else begin
              step  <= step + 4'd1;
              state <= ST_LERP_GO;
            end
          end
        end
        ST_ACC: begin
          if (last_oct) begin
            state <= fbm ? ST_NORM_GO : ST_OUT;
          end else begin
            octave <= octave + 3'd1;
            step   <= '0;
            state  <= ST_FADE_GO;
          end
        end
        ST_NORM_GO: state <= ST_NORM_WAIT;
        ST_NORM_WAIT: begin
          if (sts.mul_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Commands
  always_comb begin
    cmd             = '0;
    cmd.load_item   = accept && (mode == pnf_pkg::MODE_NOISE || mode == pnf_pkg::MODE_FBM);
    cmd.tbl_wr      = accept && (mode == pnf_pkg::MODE_LOAD);
    cmd.axis        = step[3:2];
    cmd.lerp_idx    = step[2:0];
    cmd.hash_stage  = stage;
    cmd.hash_corner = corner;
    cmd.grad_push   = push_pend;
    cmd.push_corner = push_corner;
    cmd.octave      = octave;
    cmd.oct_n       = oct_n;
    case (state)
      ST_FADE_GO, ST_FADE_WAIT: begin
        cmd.mul_start = (state == ST_FADE_GO);
        case (step[1:0])
          2'd0:    cmd.mul_op = pnf_pkg::MOP_FADE_INNER;
          2'd1:    cmd.mul_op = pnf_pkg::MOP_FADE_SQ;
          2'd2:    cmd.mul_op = pnf_pkg::MOP_FADE_CUBE;
          default: cmd.mul_op = pnf_pkg::MOP_FADE_OUT;
        endcase
      end
      ST_HASH: cmd.hash_rd = 1'b1;
      ST_LERP_GO, ST_LERP_WAIT: begin
        cmd.mul_start = (state == ST_LERP_GO);
        cmd.mul_op    = pnf_pkg::MOP_LERP;
      end
      ST_ACC: cmd.acc = 1'b1;
      ST_NORM_GO, ST_NORM_WAIT: begin
        cmd.mul_start = (state == ST_NORM_GO);
        cmd.mul_op    = pnf_pkg::MOP_NORM;
      end
      ST_OUT: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_back_to_back_start: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |=> !cmd.mul_start)
    else $error("multiplier started twice in a row");

  a_done_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |->
      (state == ST_FADE_WAIT || state == ST_LERP_WAIT || state == ST_NORM_WAIT))
    else $error("multiplier result with no operation outstanding");

  a_push_after_last_stage: assert property (@(posedge clk) disable iff (rst)
    cmd.grad_push |-> $past(state == ST_HASH && stage == 2'd2))
    else $error("gradient stored without a finished hash chain");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_octave_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC |-> ({1'b0, octave} < oct_n))
    else $error("octave counter beyond octave count");
`endif

endmodule
`default_nettype wire

FILE: hdl/perlin_noise_fbm_3d.sv
// Top level of the 3D gradient noise and fbm block.
//
//  Channel  Dir  Payload                                      Handshake
//  s_*      in   tdata: coord_x, coord_y, coord_z,            tvalid/tready
//                table_index, table_value; tuser: mode
//  m_*      out  tdata: noise_value                           tvalid/tready
//  cfg_*    in   octave_count                                 cfg_we only
//
// A table load is written as it is accepted. A noise sample runs, per octave,
// 12 fade products and 7 lerp products on the one shared multiplier plus the
// chained permutation reads; an fbm sample runs this for each of its n
// octaves and then one normalising product. Reset is synchronous and clears
// control state only; the permutation table is undefined until loaded. The
// result waits in an output register, so a stalled output delays only the next
// sample's final write.
`default_nettype none
module perlin_noise_fbm_3d (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // coord_x[31:0], coord_y[63:32], coord_z[95:64],
  // table_index[103:96], table_value[111:104]
  input  wire logic [111:0] s_tdata,
  // mode[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // noise_value[18:0], zero fill [23:19]
  output logic [23:0]       m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [3:0]   cfg_wdata
);

  pnf_pkg::cmd_t cmd;
  pnf_pkg::sts_t sts;
  logic signed [pnf_pkg::OUT_W-1:0] noise_value;

  pnf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .mode      (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  pnf_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .coord_x     ($signed(s_tdata[31:0])),
    .coord_y     ($signed(s_tdata[63:32])),
    .coord_z     ($signed(s_tdata[95:64])),
    .table_index (s_tdata[103:96]),
    .table_value (s_tdata[111:104]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .noise_value (noise_value)
  );

  assign m_tdata = {5'b0, noise_value};

endmodule
`default_nettype wire

FILE: sim/perlin_noise_fbm_3d_checker.sv
// Checker for the 3D gradient noise block: predicts each sample and compares results.
`timescale 1ns / 100ps
module perlin_noise_fbm_3d_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [111:0] s_tdata,
  input  wire logic [1:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [23:0]  m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [3:0]   cfg_wdata,
  output int                errors,
  output int                pending
);

  localparam longint ONE = 64'sd1 << 16;

  logic [7:0]  perm_copy [256];
  logic [3:0]  octaves;
  logic [18:0] noise_due [$];
  int          sample_no;

  assign pending = noise_due.size();

  // Print one mismatch line and count it
  task automatic report(input string msg);
    $display("ERROR t=%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Signed product of magnitudes, shifted right and truncated toward zero
  function automatic longint mul_sh(input longint a, input longint b, input int sh);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p  = (ua * ub) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint fade(input longint t);
    longint inner;
    longint t3;
    inner = mul_sh(t, 6 * t - 15 * ONE, 16) + 10 * ONE;
    t3    = mul_sh(mul_sh(t, t, 16), t, 16);
    return mul_sh(t3, inner, 16);
  endfunction

  function automatic longint lerp(input longint a, input longint b, input longint t);
    return a + mul_sh(t, b - a, 16);
  endfunction

  function automatic longint gradient(input logic [3:0] h, input longint x, input longint y,
                                      input longint z);
    case (h)
      4'h0: return x + y;
      4'h1: return -x + y;
      4'h2: return x - y;
      4'h3: return -x - y;
      4'h4: return x + z;
      4'h5: return -x + z;
      4'h6: return x - z;
      4'h7: return -x - z;
      4'h8: return y + z;
      4'h9: return -y + z;
      4'hA: return y - z;
      4'hB: return -y - z;
      4'hC: return y + x;
      4'hD: return -y + z;
      4'hE: return y - x;
      default: return -y - z;
    endcase
  endfunction

  function automatic logic [7:0] hash3(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] z);
    logic [7:0] h;
    h = perm_copy[x];
    h = perm_copy[8'(h + y)];
    return perm_copy[8'(h + z)];
  endfunction

  // Split into low cell bits of the truncated integer part and a signed fraction
  function automatic void split(input longint c, output logic [7:0] cel, output longint fr);
    longint unsigned m;
    longint unsigned ip;
    m   = (c < 0) ? -c : c;
    ip  = m >> 16;
    cel = (c < 0) ? 8'(-ip) : 8'(ip);
    fr  = (c < 0) ? -longint'(m & 16'hFFFF) : longint'(m & 16'hFFFF);
  endfunction

  function automatic longint noise3(input longint cx, input longint cy, input longint cz);
    logic [7:0] xi, yi, zi;
    longint xf, yf, zf, u, v, w;
    longint g [8];
    longint y1, y2;
    split(cx, xi, xf);
    split(cy, yi, yf);
    split(cz, zi, zf);
    u = fade(xf);
    v = fade(yf);
    w = fade(zf);
    // Corner index bit 0 is x, bit 1 is y, bit 2 is z
    for (int c = 0; c < 8; c++) begin
      g[c] = gradient(4'(hash3(8'(xi + c[0]), 8'(yi + c[1]), 8'(zi + c[2]))),
                      xf - c[0] * ONE, yf - c[1] * ONE, zf - c[2] * ONE);
    end
    y1 = lerp(lerp(g[0], g[1], u), lerp(g[2], g[3], u), v);
    y2 = lerp(lerp(g[4], g[5], u), lerp(g[6], g[7], u), v);
    return lerp(y1, y2, w);
  endfunction

  function automatic logic [18:0] saturate(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    if (m > (64'sd1 << 40)) m = 64'sd1 << 40;
    m = (v < 0) ? -m : m;
    if (m > pnf_pkg::OUT_MAX) m = pnf_pkg::OUT_MAX;
    if (m < pnf_pkg::OUT_MIN) m = pnf_pkg::OUT_MIN;
    return m[18:0];
  endfunction

  function automatic logic [18:0] fbm(input longint cx, input longint cy, input longint cz);
    int n;
    longint sum;
    longint nv;
    longint unsigned den;
    longint unsigned rcp;
    n = int'(octaves);
    if (n < 1) n = 1;
    if (n > pnf_pkg::MAX_OCTAVES) n = pnf_pkg::MAX_OCTAVES;
    sum = 0;
    for (int k = 0; k < n; k++) begin
      nv  = noise3(cx <<< k, cy <<< k, cz <<< k);
      sum += (nv < 0) ? -((-nv) >>> k) : (nv >>> k);
    end
    den = (64'd1 << n) - 1;
    rcp = ((64'd1 << (n + 16)) + den / 2) / den;
    return saturate(mul_sh(sum, longint'(rcp), 16));
  endfunction

  // Track requests, predict, and compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      octaves   <= 4'd4;
      errors    = 0;
      sample_no = 0;
      noise_due.delete();
    end else begin
      if (cfg_we) octaves <= cfg_wdata;
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          pnf_pkg::MODE_LOAD:  perm_copy[s_tdata[103:96]] = s_tdata[111:104];
          pnf_pkg::MODE_NOISE: noise_due.push_back(saturate(noise3(
                        longint'($signed(s_tdata[31:0])),
                        longint'($signed(s_tdata[63:32])), longint'($signed(s_tdata[95:64])))));
          pnf_pkg::MODE_FBM:   noise_due.push_back(fbm(longint'($signed(s_tdata[31:0])),
                        longint'($signed(s_tdata[63:32])), longint'($signed(s_tdata[95:64]))));
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        sample_no++;
        if (noise_due.size() == 0) begin
          report($sformatf("result %0d with nothing expected: %h", sample_no, m_tdata));
        end else begin
          if (m_tdata !== {5'd0, noise_due[0]})
            report($sformatf("result %0d noise_value got %h want %h", sample_no,
                             m_tdata, noise_due[0]));
          void'(noise_due.pop_front());
        end
      end
    end
  end

endmodule

FILE: sim/perlin_noise_fbm_3d_tb.sv
// Testbench top for the 3D gradient noise block: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module perlin_noise_fbm_3d_tb;

  localparam int CYCLE_LIMIT = 10000000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [23:0]  m_tdata;
  logic         cfg_we;
  logic [3:0]   cfg_wdata;
  int           errors;
  int           pending;
  int           cycles;
  int           burst_left;
  int unsigned  stall_cnt;

  perlin_noise_fbm_3d dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  perlin_noise_fbm_3d_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver stall pattern: free, coin flip, one in four, long random holds
  initial begin
    m_tready  = 1'b0;
    stall_cnt = 0;
    forever begin
      @(negedge clk);
      stall_cnt++;
      case (stall_cnt[12:11])
        2'd0: m_tready = 1'b1;
        2'd1: m_tready = 1'($urandom_range(0, 1));
        2'd2: m_tready = (stall_cnt[1:0] == 2'd0);
        default: m_tready = (stall_cnt[8:6] != 3'd0) ? 1'b1 : ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Present one request, holding it until accepted; random gaps between bursts
  task automatic send(input logic [1:0] md, input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] z, input logic [7:0] idx, input logic [7:0] val);
    int gap;
    if (burst_left == 0) begin
      s_tvalid   = 1'b0;
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 3);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_tuser  = md;
    s_tdata  = {val, idx, z, y, x};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    case ($urandom_range(0, 5))
      0: c = $urandom;
      1: c = {16'($urandom_range(0, 65535)), 16'h0000};
      2: c = {16'($urandom_range(0, 65535)), 16'hFFFF};
      3: c = -$urandom_range(0, 32'h0004_0000);
      default: c = $urandom_range(0, 32'h0004_0000);
    endcase
    return c;
  endfunction

  task automatic random_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)
      send(pnf_pkg::MODE_LOAD, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom));
    else if (pick < 70)
      send(pnf_pkg::MODE_NOISE, rand_coord(), rand_coord(), rand_coord(), 8'($urandom),
           8'($urandom));
    else if (pick < 93)
      send(pnf_pkg::MODE_FBM, rand_coord(), rand_coord(), rand_coord(), 8'($urandom),
           8'($urandom));
    else
      send(pnf_pkg::MODE_IGNORED, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom));
  endtask

  // Wait until every result is in, let the block settle, then write the register
  task automatic set_octaves(input logic [3:0] n);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wdata = n;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    logic [3:0] octave_plan [12];
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = pnf_pkg::MODE_LOAD;
    cfg_we     = 1'b0;
    cfg_wdata  = 4'd0;
    burst_left = 0;
    octave_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd4,
                    4'd1};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole permutation table before any sample reads it
    for (int i = 0; i < 256; i++)
      send(pnf_pkg::MODE_LOAD, $urandom, $urandom, $urandom, 8'(i), 8'($urandom));

    // Directed samples, table writes and an ignored request at reset octave count
    send(pnf_pkg::MODE_NOISE, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00);
    send(pnf_pkg::MODE_NOISE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 8'hFF);
    send(pnf_pkg::MODE_NOISE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h00, 8'h00);
    send(pnf_pkg::MODE_NOISE, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0001, 8'h00, 8'h00);
    send(pnf_pkg::MODE_NOISE, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 8'h00, 8'h00);
    send(pnf_pkg::MODE_FBM, 32'h0001_4000, 32'hFFFE_C000, 32'h0000_2000, 8'h00, 8'h00);
    send(pnf_pkg::MODE_FBM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF, 8'h00, 8'h00);
    send(pnf_pkg::MODE_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send(pnf_pkg::MODE_LOAD, 32'h0, 32'h0, 32'h0, 8'hFF, 8'h00);
    send(pnf_pkg::MODE_LOAD, 32'h0, 32'h0, 32'h0, 8'h00, 8'hFF);
    send(pnf_pkg::MODE_NOISE, 32'hFFFF_0000, 32'h00FF_0000, 32'h0100_0000, 8'h00, 8'h00);

    // Random phases over the octave settings
    foreach (octave_plan[p]) begin
      set_octaves(octave_plan[p]);
      if (p == 1)
        send(pnf_pkg::MODE_FBM, 32'h0000_FFFF, 32'hFFFF_0001, 32'h7FFF_FFFF, 8'h00, 8'h00);
      repeat (130) random_req();
    end

    // Drain and settle
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
